FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helper macros shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk_i, rst_n_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk_i, rst_n_i, expr) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk_i, rst_n_i, prop)
`define ASSERT_NEVER(lbl, clk_i, rst_n_i, expr)
`endif
`endif

FILE: rtl/sme_pkg.sv
// ---------------------------------------------------------------------------
// sme_pkg
// shared types, constants and fixed-point tables of the softmax engine
// ---------------------------------------------------------------------------
package sme_pkg;

	localparam int MAX_LEN_DEF        = 64;
	localparam int EXP_TABLE_BITS_DEF = 6;
	localparam int SCORE_W            = 16;
	localparam int RES_W              = 24;
	localparam int SUM_W              = 23;

	localparam logic [1:0] MODE_SOFTMAX = 2'd0;
	localparam logic [1:0] MODE_LOGSM   = 2'd1;
	localparam logic [1:0] MODE_LSE     = 2'd2;

	localparam logic [31:0] Q30_ONE = 32'd1073741824;

	typedef struct packed {
		logic signed [SCORE_W-1:0] max;
		logic [6:0]                count;
		logic                      ovf;
	} run_desc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_SUM_DRAIN,
		ST_LN,
		ST_EMIT,
		ST_OUT_ONE
	} back_state_t;

	function automatic logic [31:0] pow2_factor(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd1073015252;
			1: r = 32'd1072289172;
			2: r = 32'd1070838486;
			3: r = 32'd1067942999;
			4: r = 32'd1062927110;
			5: r = 32'd1050733751;
			6: r = 32'd1028218693;
			7: r = 32'd984625594;
			8: r = 32'd902905651;
			default: r = 32'd759250125;
		endcase
		return r;
	endfunction

	// elaboration-time table point 2^(-j/2^tb) in q30
	function automatic logic [31:0] pow2_point(input int j, input int tb);
		logic [63:0] v;
		int          k;
		v = 64'(Q30_ONE);
		if (j >= (1 << tb))
			return Q30_ONE >> 1;
		k = j << (10 - tb);
		for (int i = 0; i < 10; i++)
			if (((k >> i) & 1) != 0)
				v = ((v * 64'(pow2_factor(i))) + 64'(Q30_ONE >> 1)) >> 30;
		return v[31:0];
	endfunction

	function automatic logic [16:0] log2_seg(input logic [4:0] k);
		logic [16:0] r;
		case (k)
			5'd0:  r = 17'd0;
			5'd1:  r = 17'd5732;
			5'd2:  r = 17'd11136;
			5'd3:  r = 17'd16248;
			5'd4:  r = 17'd21098;
			5'd5:  r = 17'd25711;
			5'd6:  r = 17'd30109;
			5'd7:  r = 17'd34312;
			5'd8:  r = 17'd38336;
			5'd9:  r = 17'd42196;
			5'd10: r = 17'd45904;
			5'd11: r = 17'd49472;
			5'd12: r = 17'd52911;
			5'd13: r = 17'd56229;
			5'd14: r = 17'd59434;
			5'd15: r = 17'd62534;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/sme_ram.sv
// ---------------------------------------------------------------------------
// sme_ram
// generic single-write single-read ram with registered read
// ---------------------------------------------------------------------------
module sme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/sme_exp.sv
// ---------------------------------------------------------------------------
// sme_exp
// pipelined exp(-a), a in q8, result in q16, three register stages
// ---------------------------------------------------------------------------
module sme_exp #(
	parameter int EXP_TABLE_BITS = sme_pkg::EXP_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic [23:0] a,
	output logic [16:0] y
);

	localparam int TB  = EXP_TABLE_BITS;
	localparam int SHF = 16 - TB;
	localparam int NPT = (1 << TB) + 1;

	logic [31:0] pt [NPT];
	for (genvar g = 0; g < NPT; g++) begin : g_pt
		assign pt[g] = sme_pkg::pow2_point(g, TB);
	end

	logic [41:0]   t;
	logic [25:0]   n_s1;
	logic [15:0]   f_s1;
	logic [31:0]   y0_s2, dy_s2;
	logic [SHF-1:0] fr_s2;
	logic [25:0]   n_s2;
	logic [31:0]   m;
	logic [47:0]   prod;
	logic [31:0]   m_s3;
	logic [25:0]   n_s3;
	logic [TB:0]   idx, idx_nx;
	logic [5:0]    sh;
	logic [46:0]   rnd;

	assign t      = (42'(a) * 42'd94548) >> 8;
	assign idx    = {1'b0, f_s1[15:SHF]};
	assign idx_nx = idx + (TB+1)'(1);

	always_ff @(posedge clk) begin
		n_s1 <= t[41:16];
		f_s1 <= t[15:0];
		y0_s2 <= pt[idx];
		dy_s2 <= pt[idx] - pt[idx_nx];
		fr_s2 <= f_s1[SHF-1:0];
		n_s2  <= n_s1;
		m_s3  <= m;
		n_s3  <= n_s2;
	end

	assign prod = 48'(dy_s2) * 48'(fr_s2);
	assign m    = y0_s2 - 32'(prod >> SHF);

	always_comb begin
		if (n_s3 > 26'd48) begin
			y   = '0;
			sh  = '0;
			rnd = '0;
		end else begin
			sh  = 6'(n_s3) + 6'd14;
			rnd = (47'(m_s3) + (47'd1 << (sh - 6'd1))) >> sh;
			y   = rnd[16:0];
		end
	end

endmodule

FILE: rtl/sme_front.sv
// ---------------------------------------------------------------------------
// sme_front
// accepts scores, writes the store, tracks the max and queues run descriptors
// ---------------------------------------------------------------------------
module sme_front #(
	parameter int MAX_LEN = sme_pkg::MAX_LEN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [sme_pkg::SCORE_W-1:0] score,
	input  logic                             last_in,
	output logic                             we,
	output logic [$clog2(MAX_LEN)-1:0]       waddr,
	output logic [sme_pkg::SCORE_W-1:0]      wdata,
	output logic                             desc_valid,
	output sme_pkg::run_desc_t               desc,
	input  logic                             desc_take
);

	logic signed [sme_pkg::SCORE_W-1:0] max_q;
	logic [6:0]                         cnt_q;
	logic                               ovf_q;
	logic                               full_q;
	sme_pkg::run_desc_t                 desc_q;
	logic                               acc, room;
	logic signed [sme_pkg::SCORE_W-1:0] nmax;

	// one-entry descriptor queue; the store is shared so a new run waits
	assign in_stall   = full_q;
	assign acc        = in_valid && !in_stall;
	assign room       = cnt_q < 7'(MAX_LEN);
	assign we         = acc && room;
	assign waddr      = cnt_q[$clog2(MAX_LEN)-1:0];
	assign wdata      = score;
	assign nmax       = (room && score > max_q) ? score : max_q;
	assign desc_valid = full_q;
	assign desc       = desc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= 16'sh8000;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			full_q <= 1'b0;
		end else begin
			if (desc_take)
				full_q <= 1'b0;
			if (acc) begin
				if (last_in) begin
					desc_q.max   <= nmax;
					desc_q.count <= room ? cnt_q + 7'd1 : cnt_q;
					desc_q.ovf   <= ovf_q || !room;
					full_q       <= 1'b1;
					max_q        <= 16'sh8000;
					cnt_q        <= '0;
					ovf_q        <= 1'b0;
				end else begin
					max_q <= nmax;
					if (room)
						cnt_q <= cnt_q + 7'd1;
					else
						ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/sme_back.sv
// ---------------------------------------------------------------------------
// sme_back
// sums exp terms, takes the log and emits the results of one run
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module sme_back #(
	parameter int MAX_LEN        = sme_pkg::MAX_LEN_DEF,
	parameter int EXP_TABLE_BITS = sme_pkg::EXP_TABLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      mode,
	input  logic                            desc_valid,
	input  sme_pkg::run_desc_t              desc,
	output logic                            desc_take,
	output logic [$clog2(MAX_LEN)-1:0]      raddr,
	input  logic [sme_pkg::SCORE_W-1:0]     rdata,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [sme_pkg::RES_W-1:0] result_value,
	output logic                            status,
	output logic                            last_out
);

	localparam int AW  = $clog2(MAX_LEN);
	localparam int LAT = 5; // ram read, input register and three exp stages

	sme_pkg::back_state_t st_q, st_d;
	sme_pkg::run_desc_t   run_q;
	logic [6:0]  rd_q;        // next read index
	logic [6:0]  ret_q;       // results finished
	logic [LAT-1:0] vpipe_q;  // read valid along the pipeline
	logic [LAT-1:0] lpipe_q;
	logic [sme_pkg::SUM_W-1:0] sum_q;
	logic signed [23:0] lnorm_q;
	logic signed [sme_pkg::SCORE_W-1:0] xpipe_s1;
	logic [1:0]  mode_q;
	logic [1:0]  ln_step_q;
	logic [31:0] lg_q;
	logic [47:0] lnp_q;

	// output skid: 4-entry queue so stalls do not lose in-flight terms
	logic [25:0] fifo_q [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  fc_q;

	logic        issue, push, pop;
	logic [23:0] a_in;
	logic [16:0] ey;
	logic signed [23:0] d;
	logic [25:0] pdat;
	logic        emit;
	logic        in_flight;
	logic        start;

	assign raddr  = rd_q[AW-1:0];
	assign emit   = (st_q == sme_pkg::ST_EMIT);

	// exp argument aligned with ram output
	always_comb begin
		if (emit)
			d = 24'(signed'(xpipe_s1)) - lnorm_q;
		else
			d = 24'(signed'(run_q.max)) - 24'(signed'(xpipe_s1));
		if (emit)
			a_in = d[23] ? -d : 24'd0;
		else
			a_in = d;
	end

	sme_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp (
		.clk (clk),
		.a   (a_in),
		.y   (ey)
	);

	// d for the emit path, carried with the exp pipeline
	logic signed [23:0] dd_s2, dd_s3, dd_s4;

	always_ff @(posedge clk) begin
		xpipe_s1 <= rdata;
		dd_s2    <= d;
		dd_s3    <= dd_s2;
		dd_s4    <= dd_s3;
	end

	assign in_flight = |vpipe_q;
	assign issue = (st_q == sme_pkg::ST_SUM || (emit && fc_q + 3'($countones(vpipe_q)) < 3'd3))
		&& rd_q < run_q.count;
	assign push  = emit && vpipe_q[LAT-1];

	always_comb begin
		if (mode_q == sme_pkg::MODE_SOFTMAX)
			pdat[23:0] = (!dd_s4[23]) ? 24'd65535 : (ey > 17'd65535 ? 24'd65535 : 24'(ey));
		else
			pdat[23:0] = dd_s4;
		pdat[24] = 1'b0;
		pdat[25] = lpipe_q[LAT-1];
	end

	// ln of the sum: normalize, interpolate, scale by ln 2
	logic [31:0] s;
	logic [4:0]  msb;
	logic [31:0] mn, u;
	logic [3:0]  sidx;
	logic [25:0] sfr;
	logic [16:0] seg0, seg1;
	logic [42:0] ip;
	always_comb begin
		s = (sum_q < 23'd65536) ? 32'd65536 : 32'(sum_q);
		msb = 5'd16;
		for (int b = 17; b < 23; b++)
			if (s[b])
				msb = 5'(b);
		mn   = s << (5'd30 - msb);
		u    = mn - sme_pkg::Q30_ONE;
		sidx = u[29:26];
		sfr  = u[25:0];
		seg0 = sme_pkg::log2_seg({1'b0, sidx});
		seg1 = sme_pkg::log2_seg({1'b0, sidx} + 5'd1);
		ip   = 43'(seg1 - seg0) * 43'(sfr);
	end

	logic [47:0] lnq16;
	assign lnq16 = (lnp_q + 48'd32768) >> 16;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			sme_pkg::ST_IDLE:
				if (desc_valid)
					st_d = desc.ovf ? sme_pkg::ST_OUT_ONE : sme_pkg::ST_SUM;
			sme_pkg::ST_SUM:
				if (!(rd_q < run_q.count))
					st_d = sme_pkg::ST_SUM_DRAIN;
			sme_pkg::ST_SUM_DRAIN:
				if (!in_flight)
					st_d = sme_pkg::ST_LN;
			sme_pkg::ST_LN:
				if (ln_step_q == 2'd2)
					st_d = (mode_q == sme_pkg::MODE_SOFTMAX || mode_q == sme_pkg::MODE_LOGSM)
						? sme_pkg::ST_EMIT : sme_pkg::ST_OUT_ONE;
			sme_pkg::ST_EMIT:
				if (ret_q == run_q.count && fc_q == 3'd0)
					st_d = sme_pkg::ST_IDLE;
			sme_pkg::ST_OUT_ONE:
				if (fc_q == 3'd0 && ret_q != 7'd0)
					st_d = sme_pkg::ST_IDLE;
			default: st_d = sme_pkg::ST_IDLE;
		endcase
	end

	// the store is shared, so the descriptor is released only when the run is done
	assign start     = (st_q == sme_pkg::ST_IDLE) && desc_valid;
	assign desc_take = (st_q != sme_pkg::ST_IDLE) && (st_d == sme_pkg::ST_IDLE);

	logic        one_push;
	logic [25:0] one_dat;
	assign one_push = (st_q == sme_pkg::ST_OUT_ONE) && ret_q == 7'd0;
	assign one_dat  = {1'b1, run_q.ovf, run_q.ovf ? 24'd0 : lnorm_q};

	assign out_valid    = fc_q != 3'd0;
	assign pop          = out_valid && !out_stall;
	assign result_value = fifo_q[rp_q][23:0];
	assign status       = fifo_q[rp_q][24];
	assign last_out     = fifo_q[rp_q][25];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wp_q] <= pdat;
		else if (one_push)
			fifo_q[wp_q] <= one_dat;
		if (start)
			run_q <= desc;
		if (st_q == sme_pkg::ST_LN && ln_step_q == 2'd0)
			lg_q <= 32'(msb - 5'd16) * 32'd65536 + 32'(seg0) + 32'(ip >> 26);
		if (st_q == sme_pkg::ST_LN && ln_step_q == 2'd1)
			lnp_q <= 48'(lg_q) * 48'd45426;
		if (st_q == sme_pkg::ST_LN && ln_step_q == 2'd2)
			lnorm_q <= 24'(signed'(run_q.max)) + 24'((lnq16 + 48'd128) >> 8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= sme_pkg::ST_IDLE;
			rd_q      <= '0;
			ret_q     <= '0;
			vpipe_q   <= '0;
			lpipe_q   <= '0;
			sum_q     <= '0;
			mode_q    <= sme_pkg::MODE_SOFTMAX;
			ln_step_q <= '0;
			wp_q      <= '0;
			rp_q      <= '0;
			fc_q      <= '0;
		end else begin
			st_q    <= st_d;
			vpipe_q <= {vpipe_q[LAT-2:0], issue};
			lpipe_q <= {lpipe_q[LAT-2:0], rd_q + 7'd1 == run_q.count};
			if (push || one_push)
				wp_q <= wp_q + 2'd1;
			if (pop)
				rp_q <= rp_q + 2'd1;
			fc_q <= fc_q + 3'(push || one_push) - 3'(pop);
			if (issue)
				rd_q <= rd_q + 7'd1;
			if (st_q == sme_pkg::ST_SUM && vpipe_q[LAT-1] || st_q == sme_pkg::ST_SUM_DRAIN
				&& vpipe_q[LAT-1])
				sum_q <= sum_q + 23'(ey);
			if (push || one_push)
				ret_q <= ret_q + 7'd1;
			if (st_q == sme_pkg::ST_LN)
				ln_step_q <= ln_step_q + 2'd1;
			if (start) begin
				mode_q <= (mode == 2'd3) ? sme_pkg::MODE_LSE : mode;
				rd_q   <= '0;
				sum_q  <= '0;
				ret_q  <= '0;
			end
			if (st_q == sme_pkg::ST_SUM_DRAIN && !in_flight) begin
				rd_q  <= '0;
				ln_step_q <= '0;
			end
		end
	end

	`ASSERT_NEVER(a_fifo_ovf, clk, arst_n, fc_q > 3'd4)
	`ASSERT_NEVER(a_push_idle, clk, arst_n, (push || one_push) && st_q == sme_pkg::ST_IDLE)
	`ASSERT_IMPL(a_start_busy, clk, arst_n, start |=> st_q != sme_pkg::ST_IDLE)

endmodule

FILE: rtl/softmax_logsumexp_engine.sv
// ---------------------------------------------------------------------------
// softmax_logsumexp_engine
// stable softmax, log-softmax and logsumexp over vectors of q7.8 scores
// ---------------------------------------------------------------------------
// A vector loads at one score per cycle; after the last score the back end
// reads the score memory once to sum exp terms (one read per cycle, then the
// ram read and exp pipeline drains), takes the log of the sum, then reads the
// memory again to emit the results. The emit pass keeps at most three reads
// in flight against the four-entry output queue, so an output stall never
// overflows the queue. Both passes read the single score memory, so the input
// stalls from the last score of a vector until the back end has finished that
// run.
module softmax_logsumexp_engine #(
	parameter int MAX_LEN        = sme_pkg::MAX_LEN_DEF,
	parameter int EXP_TABLE_BITS = sme_pkg::EXP_TABLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [sme_pkg::SCORE_W-1:0] score,
	input  logic                             last_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [sme_pkg::RES_W-1:0] result_value,
	output logic                             status,
	output logic                             last_out
);

	localparam int AW = $clog2(MAX_LEN);

	logic [1:0] mode_q;
	logic       we, desc_valid, desc_take;
	logic [AW-1:0] waddr, raddr;
	logic [sme_pkg::SCORE_W-1:0] wdata, rdata;
	sme_pkg::run_desc_t desc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= sme_pkg::MODE_SOFTMAX;
		else if (cfg_valid && cfg_ready)
			mode_q <= cfg_data;
	end

	sme_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .score, .last_in,
		.we, .waddr, .wdata, .desc_valid, .desc, .desc_take
	);

	sme_ram #(.WIDTH(sme_pkg::SCORE_W), .DEPTH(MAX_LEN)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	sme_back #(.MAX_LEN(MAX_LEN), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_back (
		.clk, .arst_n, .mode(mode_q), .desc_valid, .desc, .desc_take, .raddr, .rdata,
		.out_valid, .out_stall, .result_value, .status, .last_out
	);

endmodule

FILE: tb/sme_checker.sv
// ---------------------------------------------------------------------------
// sme_checker
// predicts and checks the results of the softmax engine
// ---------------------------------------------------------------------------
// Watches the mode write, score and result channels. Each accepted score is
// stored in its own copy of the vector. At the last score it computes the exp
// sum, log normalizer and per-element (or single) results in fixed point and
// queues them. Each accepted result is compared with the oldest queued one.
module sme_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [1:0]                          cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [sme_pkg::SCORE_W-1:0]  score,
	input  logic                                last_in,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [sme_pkg::RES_W-1:0]    result_value,
	input  logic                                status,
	input  logic                                last_out,
	output int                                  fail_count,
	output int                                  pending
);

	typedef struct {
		logic [sme_pkg::RES_W-1:0] value;
		logic                      st;
		logic                      lst;
	} sme_result_t;

	localparam int VEC_CAP = sme_pkg::MAX_LEN_DEF;
	localparam int TBITS   = sme_pkg::EXP_TABLE_BITS_DEF;

	sme_result_t            result_q[$];
	logic signed [15:0]     vec_scores[VEC_CAP];
	int                     vec_len;
	int                     vec_max;
	logic                   vec_ovf;
	logic [1:0]             cur_mode;

	const longint unsigned half_factors[10] = '{
		1073015252, 1072289172, 1070838486, 1067942999, 1062927110,
		1050733751, 1028218693, 984625594, 902905651, 759250125
	};
	const longint unsigned seg_log2[17] = '{
		0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
		42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536
	};

	function automatic longint unsigned neg_pow2_q30(int j);
		longint unsigned v;
		int              k;
		v = 64'd1 << 30;
		if (j >= (1 << TBITS))
			return 64'd1 << 29;
		k = j << (10 - TBITS);
		for (int i = 0; i < 10; i++)
			if (((k >> i) & 1) != 0)
				v = (v * half_factors[i] + (64'd1 << 29)) >> 30;
		return v;
	endfunction

	function automatic longint unsigned exp_neg_q16(longint unsigned a);
		longint unsigned t, n, f, idx, fr, y0, y1, m, sh;
		int              shf;
		shf = 16 - TBITS;
		t = (a * 64'd94548) >> 8;
		n = t >> 16;
		f = t & 64'hFFFF;
		idx = f >> shf;
		fr = f & ((64'd1 << shf) - 1);
		y0 = neg_pow2_q30(int'(idx));
		y1 = neg_pow2_q30(int'(idx) + 1);
		m = y0 - (((y0 - y1) * fr) >> shf);
		sh = 14 + n;
		if (sh > 62)
			return 0;
		return (m + (64'd1 << (sh - 1))) >> sh;
	endfunction

	function automatic int ln_q8(longint unsigned s);
		longint unsigned m, u, fr, lg, lnq;
		int              msb, idx;
		if (s < 65536)
			s = 65536;
		msb = 16;
		while (msb < 31 && (s >> (msb + 1)) != 0)
			msb++;
		m = s << (30 - msb);
		u = m - (64'd1 << 30);
		idx = int'(u >> 26);
		fr = u & ((64'd1 << 26) - 1);
		lg = longint'(msb - 16) * 65536 + seg_log2[idx]
			+ (((seg_log2[idx + 1] - seg_log2[idx]) * fr) >> 26);
		lnq = (lg * 64'd45426 + 32768) >> 16;
		return int'((lnq + 128) >> 8);
	endfunction

	task automatic finish_vector();
		longint unsigned sum;
		int              norm_q8, d;
		longint unsigned p;
		sme_result_t     r;
		if (vec_ovf) begin
			r.value = '0;
			r.st = 1'b1;
			r.lst = 1'b1;
			result_q.push_back(r);
			return;
		end
		sum = 0;
		for (int i = 0; i < vec_len; i++)
			sum += exp_neg_q16(longint'(vec_max - int'(vec_scores[i])));
		sum &= 64'h7FFFFF;
		norm_q8 = vec_max + ln_q8(sum);
		if (cur_mode == sme_pkg::MODE_SOFTMAX || cur_mode == sme_pkg::MODE_LOGSM) begin
			for (int i = 0; i < vec_len; i++) begin
				d = int'(vec_scores[i]) - norm_q8;
				if (cur_mode == sme_pkg::MODE_SOFTMAX) begin
					p = (d >= 0) ? 65536 : exp_neg_q16(longint'(-d));
					if (p > 65535)
						p = 65535;
					r.value = p[sme_pkg::RES_W-1:0];
				end else begin
					r.value = d[sme_pkg::RES_W-1:0];
				end
				r.st = 1'b0;
				r.lst = (i + 1 == vec_len);
				result_q.push_back(r);
			end
		end else begin
			r.value = norm_q8[sme_pkg::RES_W-1:0];
			r.st = 1'b0;
			r.lst = 1'b1;
			result_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sme_result_t r;
		if (!arst_n) begin
			cur_mode = sme_pkg::MODE_SOFTMAX;
			vec_len = 0;
			vec_max = -32768;
			vec_ovf = 1'b0;
			fail_count = 0;
			result_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				cur_mode = cfg_data;
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result value=%0h status=%0b last=%0b",
							result_value, status, last_out);
				end else begin
					r = result_q.pop_front();
					if (result_value !== r.value || status !== r.st || last_out !== r.lst) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %0h/%0b/%0b got %0h/%0b/%0b",
								r.value, r.st, r.lst, result_value, status, last_out);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (vec_len < VEC_CAP) begin
					vec_scores[vec_len] = score;
					vec_len++;
					if (int'(score) > vec_max)
						vec_max = int'(score);
				end else begin
					vec_ovf = 1'b1;
				end
				if (last_in) begin
					finish_vector();
					vec_len = 0;
					vec_max = -32768;
					vec_ovf = 1'b0;
				end
			end
		end
		pending = result_q.size();
	end

endmodule

FILE: tb/tb_softmax_logsumexp_engine.sv
// ---------------------------------------------------------------------------
// tb_softmax_logsumexp_engine
// stimulus and verdict for the softmax engine
// ---------------------------------------------------------------------------
// Sends directed and random score vectors in every mode, with random idle
// cycles on both channels, one long result hold-off and pauses until all
// results are back. Checking is done by sme_checker.
module tb_softmax_logsumexp_engine;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [1:0]                           cfg_data;
	logic                                 in_valid;
	logic                                 in_stall;
	logic signed [sme_pkg::SCORE_W-1:0]   score;
	logic                                 last_in;
	logic                                 out_valid;
	logic                                 out_stall;
	logic signed [sme_pkg::RES_W-1:0]     result_value;
	logic                                 status;
	logic                                 last_out;
	int                                   fail_count;
	int                                   pending;
	int                                   snd_idle;
	int                                   rcv_idle;
	logic                                 long_hold;

	softmax_logsumexp_engine uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .score(score), .last_in(last_in),
		.out_valid(out_valid), .out_stall(out_stall), .result_value(result_value),
		.status(status), .last_out(last_out)
	);

	sme_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .score(score), .last_in(last_in),
		.out_valid(out_valid), .out_stall(out_stall), .result_value(result_value),
		.status(status), .last_out(last_out),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk)
		out_stall <= long_hold || ($urandom_range(99) < rcv_idle);

	task automatic send_score(input logic signed [15:0] s, input logic l);
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < snd_idle)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		score <= s;
		last_in <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_vector();
		int len, center, spread, v;
		len = $urandom_range(1, 4);
		center = $urandom_range(65535) - 32768;
		spread = ($urandom_range(3) == 0) ? 65535 : $urandom_range(1, 2048);
		for (int i = 0; i < len; i++) begin
			if (spread == 65535)
				v = $urandom_range(65535) - 32768;
			else
				v = center + $urandom_range(2 * spread) - spread;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			send_score(16'(v), i == len - 1);
		end
	endtask

	initial begin
		#(12 * 600000);
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = sme_pkg::MODE_SOFTMAX;
		in_valid = 1'b0;
		score = '0;
		last_in = 1'b0;
		long_hold = 1'b0;
		snd_idle = 0;
		rcv_idle = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed vectors in each mode
		for (int m = 0; m < 4; m++) begin
			write_mode(2'(m));
			send_score(16'sh7FFF, 1'b1);
			send_score(16'sh8000, 1'b0);
			send_score(16'sh7FFF, 1'b1);
			send_score(16'sd256, 1'b0);
			send_score(16'sd256, 1'b0);
			send_score(16'sd0, 1'b1);
		end
		write_mode(sme_pkg::MODE_SOFTMAX);
		for (int i = 0; i < sme_pkg::MAX_LEN_DEF + 1; i++)
			send_score(16'(i * 7), i == sme_pkg::MAX_LEN_DEF);

		// random phases
		for (int ph = 0; ph < 3; ph++) begin
			snd_idle = (ph == 0) ? 16 : (ph == 1) ? 63 : 0;
			rcv_idle = (ph == 0) ? 63 : (ph == 1) ? 16 : 0;
			for (int m = 0; m < 4; m++) begin
				write_mode((ph == 2 && m == 3) ? sme_pkg::MODE_LOGSM : 2'(m));
				if (ph == 2 && m == 0) begin
					fork
						begin
							long_hold <= 1'b1;
							repeat (400) @(posedge clk);
							long_hold <= 1'b0;
						end
					join_none
					for (int i = 0; i < 10; i++)
						send_score(16'($urandom_range(65535)), i == 9);
				end
				send_random_vector();
			end
		end

		drain_results();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
